[rtl/core/assert_macros.svh]
// Assertion macros shared by the frame modulator RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high
`define FCFM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define FCFM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/fcfm_pkg.sv]
// Package for the FSK character frame modulator: widths, codes, status structs
// and the frame builder. No dependencies.
`default_nettype none

package fcfm_pkg;

   localparam int FIFO_DEPTH_DEF = 4096;
   localparam int CHAR_W         = 8;
   localparam int FRAME_LEN      = 1 + CHAR_W + 1 + 1;
   localparam int POS_W          = 4;
   localparam int LEVEL_W        = 13;
   localparam int RSP_W          = 3 + LEVEL_W;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic tone;
      logic sending;
   } tone_stat_type;

   // start 0, data MSB first, parity, stop 1; bit k is sent k-th
   function automatic logic [FRAME_LEN-1:0] build_frame(input logic [CHAR_W-1:0] ch,
                                                        input logic par_odd);
      logic [FRAME_LEN-1:0] frame;
      frame = '0;
      for (int i = 0; i < CHAR_W; i++) begin
         frame[CHAR_W - i] = ch[i];
      end
      frame[CHAR_W + 1] = (^ch) ^ par_odd;
      frame[CHAR_W + 2] = 1'b1;
      return frame;
   endfunction

endpackage

`default_nettype wire

[rtl/core/fcfm_fifo.sv]
// Character queue: circular buffer in a synchronous memory with head, tail, count.
// Depends on fcfm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcfm_fifo
   import fcfm_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
   parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_en,
   input  wire logic [CHAR_W-1:0] push_data,
   input  wire logic              pop_en,
   output logic      [CHAR_W-1:0] rd_data,
   output fifo_stat_type          stat,
   output logic      [CNT_W-1:0]  count_next
);

   localparam int AW = $clog2(FIFO_DEPTH);

   logic [CHAR_W-1:0] mem [FIFO_DEPTH];
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CHAR_W-1:0] rd_data_ff;

   assign stat.full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      unique case ({push_en, pop_en})
         2'b10: begin
            head_in  = (head_ff == AW'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end
         2'b01: begin
            tail_in  = (tail_ff == AW'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[head_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_en) begin
         rd_data_ff <= mem[tail_ff];
      end
   end

   assign rd_data    = rd_data_ff;
   assign count_next = count_in;

   `FCFM_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(FIFO_DEPTH), "fifo count over depth")
   `FCFM_ASSERT(a_no_underflow, clock, reset, pop_en |-> (count_ff != '0 && !push_en), "pop from empty fifo or with push")
   `FCFM_ASSERT(a_no_overflow, clock, reset, push_en |-> !stat.full, "push into full fifo")

endmodule

`default_nettype wire

[rtl/core/fcfm_framer.sv]
// Frame sequencer: loads a character from the queue and steps its 11 frame bits
// out as tone selections. Depends on fcfm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcfm_framer
   import fcfm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              tick_en,
   input  wire logic              parity_odd,
   input  wire fifo_stat_type     fifo_stat,
   input  wire logic [CHAR_W-1:0] rd_data,
   output logic                   pop_en,
   output tone_stat_type          tone_next
);

   logic                 sending_ff, sending_in;
   logic                 tone_ff, tone_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [FRAME_LEN-1:0] frame_ff, frame_in;
   logic                 pending_ff;
   logic [FRAME_LEN-1:0] frame_eff;

   // read data lands in the cycle after the pop; use it directly in that cycle
   assign frame_eff = pending_ff ? build_frame(rd_data, parity_odd) : frame_ff;
   assign frame_in  = frame_eff;
   assign pop_en    = tick_en && !sending_ff && !fifo_stat.empty;

   always_comb begin
      sending_in = sending_ff;
      tone_in    = tone_ff;
      pos_in     = pos_ff;
      priority if (!tick_en) begin
      end else if (!sending_ff) begin
         if (pop_en) begin
            sending_in = 1'b1;
            pos_in     = '0;
            tone_in    = 1'b1;
         end
      end else if (pos_ff >= POS_W'(FRAME_LEN)) begin
         sending_in = 1'b0;
         pos_in     = '0;
         tone_in    = 1'b1;
      end else begin
         tone_in = frame_eff[pos_ff];
         pos_in  = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         tone_ff    <= 1'b1;
         pos_ff     <= '0;
         pending_ff <= 1'b0;
      end else begin
         sending_ff <= sending_in;
         tone_ff    <= tone_in;
         pos_ff     <= pos_in;
         pending_ff <= pop_en;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign tone_next.tone    = tone_in;
   assign tone_next.sending = sending_in;

   `FCFM_ASSERT(a_pos_bound, clock, reset, pos_ff <= POS_W'(FRAME_LEN), "bit position past frame")
   `FCFM_ASSERT(a_end_of_frame, clock, reset, $fell(sending_ff) |-> $past(pos_ff) == POS_W'(FRAME_LEN), "frame ended early")
   `FCFM_ASSERT(a_pending_busy, clock, reset, pending_ff |-> sending_ff, "load pending while idle")

endmodule

`default_nettype wire

[rtl/core/fsk_char_frame_modulator.sv]
//  channel  | dir | handshake              | payload
//  req_     | in  | req_tvalid/req_tready  | tdata: char_in[7:0]; tuser: operation
//  rsp_     | out | rsp_tvalid/rsp_tready  | tdata: tone_mark, busy_res, accepted,
//           |     |                        |        fifo_level[12:0]
//  csr_     | in  | csr_valid/csr_ready    | csr_data: parity_odd
//  One word per cycle each way while no result is held; each word's result is
//  registered in the output register. Rate is set by the single-port-write,
//  single-port-read character memory: one push or one pop per cycle.
//  Reset is synchronous and clears pointers, count and frame state; memory needs none.
//  A held result stalls the input only when rsp_tready is low.
// Top level of the FSK character frame modulator; depends on fcfm_pkg,
// fcfm_fifo and fcfm_framer.
`default_nettype none

module fsk_char_frame_modulator
   import fcfm_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [CHAR_W-1:0] req_tdata,   // [7:0] char_in
   input  wire logic              req_tuser,   // [0] operation
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [RSP_W-1:0]  rsp_tdata,   // [0] tone_mark, [1] busy_res, [2] accepted,
                                               // [15:3] fifo_level
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_data     // [0] parity_odd
);

   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic                     req_fire;
   logic                     push_en;
   logic                     tick_en;
   logic                     pop_en;
   fifo_stat_type            fifo_stat;
   tone_stat_type            tone_next;
   logic [CHAR_W-1:0]        rd_data;
   logic [CNT_W-1:0]         count_next;
   logic [CNT_W+LEVEL_W-1:0] count_ext;
   logic                     parity_odd_ff, parity_odd_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign push_en    = req_fire && (req_tuser == OP_PUSH) && !fifo_stat.full;
   assign tick_en    = req_fire && (req_tuser == OP_TICK);

   assign csr_ready     = 1'b1;
   assign parity_odd_in = (csr_valid && csr_ready) ? csr_data : parity_odd_ff;

   fcfm_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .CNT_W      (CNT_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (push_en),
      .push_data  (req_tdata),
      .pop_en     (pop_en),
      .rd_data    (rd_data),
      .stat       (fifo_stat),
      .count_next (count_next)
   );

   fcfm_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (tick_en),
      .parity_odd (parity_odd_ff),
      .fifo_stat  (fifo_stat),
      .rd_data    (rd_data),
      .pop_en     (pop_en),
      .tone_next  (tone_next)
   );

   assign count_ext   = {{LEVEL_W{1'b0}}, count_next};
   assign rsp_data_in = req_fire ?
                        {count_ext[LEVEL_W-1:0], push_en, tone_next.sending, tone_next.tone} :
                        rsp_data_ff;
   assign rsp_valid_in = req_fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         parity_odd_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         parity_odd_ff <= parity_odd_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[tb/fsk_char_frame_modulator_test.sv]
// Self-checking bench for fsk_char_frame_modulator: push and tick words in, one
// status word out per input, checked against a frame and FIFO predictor.
// Depends on fcfm_pkg and the modulator RTL.

import fcfm_pkg::*;

typedef struct packed {
   logic [LEVEL_W-1:0] level;
   logic               accepted;
   logic               busy;
   logic               tone;
} tone_word_type;

class tone_board;
   logic [CHAR_W-1:0]    queued[$];
   logic [FRAME_LEN-1:0] frame;
   int unsigned          bit_idx;
   logic                 sending;
   logic                 tone;
   logic                 odd_parity;
   tone_word_type        due[$];
   int unsigned          errors;

   function new();
      frame      = '0;
      bit_idx    = 0;
      sending    = 1'b0;
      tone       = 1'b1;
      odd_parity = 1'b0;
      errors     = 0;
   endfunction

   function void set_parity(input logic odd);
      odd_parity = odd;
   endfunction

   function int unsigned pending();
      return due.size();
   endfunction

   function void note_word(input op_type op, input logic [CHAR_W-1:0] ch);
      tone_word_type     w;
      logic [CHAR_W-1:0] c;
      int                i;
      w.accepted = 1'b0;
      if (op == OP_PUSH) begin
         if (queued.size() < FIFO_DEPTH_DEF) begin
            queued.push_back(ch);
            w.accepted = 1'b1;
         end
      end else if (!sending) begin
         if (queued.size() > 0) begin
            c = queued.pop_front();
            frame[0] = 1'b0;
            for (i = 0; i < CHAR_W; i++) begin
               frame[CHAR_W - i] = c[i];
            end
            frame[CHAR_W + 1] = (^c) ^ odd_parity;
            frame[CHAR_W + 2] = 1'b1;
            bit_idx = 0;
            sending = 1'b1;
            tone    = 1'b1;
         end
      end else if (bit_idx >= FRAME_LEN) begin
         sending = 1'b0;
         bit_idx = 0;
         tone    = 1'b1;
      end else begin
         tone = frame[bit_idx];
         bit_idx++;
      end
      w.tone  = tone;
      w.busy  = sending;
      w.level = LEVEL_W'(queued.size());
      due.push_back(w);
   endfunction

   function void check_word(input logic [RSP_W-1:0] data);
      tone_word_type got;
      tone_word_type want;
      got = data;
      if (due.size() == 0) begin
         errors++;
         $error("result word with nothing pending: %h", data);
      end else begin
         want = due.pop_front();
         if (got.tone !== want.tone) begin
            errors++;
            $error("tone_mark: expected %0d, actual %0d", want.tone, got.tone);
         end
         if (got.busy !== want.busy) begin
            errors++;
            $error("busy_res: expected %0d, actual %0d", want.busy, got.busy);
         end
         if (got.accepted !== want.accepted) begin
            errors++;
            $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
         end
         if (got.level !== want.level) begin
            errors++;
            $error("fifo_level: expected %0d, actual %0d", want.level, got.level);
         end
      end
   endfunction
endclass

module fsk_char_frame_modulator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT = 400000;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [CHAR_W-1:0] req_tdata  = '0;
   logic              req_tuser  = OP_TICK;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic              csr_data   = 1'b0;
   logic              calm       = 1'b0;
   int unsigned       cycles     = 0;
   tone_board         board      = new();

   fsk_char_frame_modulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("fsk_char_frame_modulator_test: errors");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) board.set_parity(csr_data);
         if (req_tvalid && req_tready) board.note_word(op_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 7);
   end

   task automatic send_word(input op_type op, input logic [CHAR_W-1:0] ch);
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_words();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_parity(input logic odd);
      drain_words();
      csr_valid <= 1'b1;
      csr_data  <= odd;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_words(input int unsigned count, input int unsigned push_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < push_pct) send_word(OP_PUSH, CHAR_W'($urandom));
         else send_word(OP_TICK, CHAR_W'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_parity(1'b0);

      send_word(OP_TICK, 8'h00);
      send_word(OP_PUSH, 8'h00);
      send_word(OP_PUSH, 8'hFF);
      send_word(OP_PUSH, 8'h80);
      repeat (13) send_word(OP_TICK, 8'hFF);
      repeat (3) send_word(OP_TICK, 8'h00);
      send_word(OP_PUSH, 8'h01);
      send_word(OP_PUSH, 8'h7F);

      write_parity(1'b1);
      random_words(300, 20);
      calm = 1'b1;
      write_parity(1'b0);
      random_words(300, 4);
      calm = 1'b0;
      write_parity(1'b1);
      random_words(300, 9);

      drain_words();
      repeat (10) @(posedge clock);
      if (board.errors == 0) $display("fsk_char_frame_modulator_test: clean");
      else $display("fsk_char_frame_modulator_test: errors");
      $finish;
   end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/fcfm_pkg.sv
rtl/core/fcfm_fifo.sv
rtl/core/fcfm_framer.sv
rtl/core/fsk_char_frame_modulator.sv
tb/fsk_char_frame_modulator_test.sv
